@@ rtl/core/nhd_pkg.sv @@
// ----------------------------------------------------------------------------
// nhd_pkg
// Shared types, constants and helpers for the volume header decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package nhd_pkg;

  localparam int MAX_RANK = 7;

  localparam logic [31:0] HDR_ONE    = 32'd348;
  localparam logic [31:0] HDR_TWO    = 32'd540;
  localparam logic [9:0]  STORE_SIZE = 10'd540;

  localparam logic [7:0] CH_N    = 8'h6E;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_I    = 8'h69;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_TWO  = 8'h32;

  localparam logic [31:0] ONE_F32 = 32'h3F80_0000;
  localparam logic [63:0] ONE_F64 = 64'h3FF0_0000_0000_0000;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_SIZE      = 3'd2;
  localparam logic [2:0] ST_MAGIC     = 3'd3;
  localparam logic [2:0] ST_RANK      = 3'd4;
  localparam logic [2:0] ST_TYPE      = 3'd5;
  localparam logic [2:0] ST_EXTENT    = 3'd6;
  localparam logic [2:0] ST_OFFSET    = 3'd7;

  // record kinds
  localparam logic [1:0] RK_AXIS   = 2'd0;
  localparam logic [1:0] RK_OFFSET = 2'd1;
  localparam logic [1:0] RK_TOTAL  = 2'd2;

  // element kinds
  localparam logic [1:0] EK_UNSIGNED = 2'd0;
  localparam logic [1:0] EK_SIGNED   = 2'd1;
  localparam logic [1:0] EK_FLOAT    = 2'd2;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       final_byte;
  } nhd_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  record_kind;
    logic [2:0]  axis_index;
    logic [2:0]  axis_label;
    logic [62:0] value;
    logic [3:0]  elem_size;
    logic [1:0]  elem_class;
    logic [2:0]  rank;
    logic        swap_bytes;
    logic        paired_files;
    logic        scaled;
    logic        last;
  } nhd_out_t;

  // decoded header handed from the front to the back
  typedef struct packed {
    logic [2:0]                 code;
    logic                       off_bad;
    logic [2:0]                 rank;
    logic [3:0]                 ebytes;
    logic [1:0]                 ekind;
    logic                       swap;
    logic                       paired;
    logic                       scaled;
    logic [62:0]                offset;
    logic [MAX_RANK-1:0][62:0]  ext;
  } nhd_job_t;

  typedef struct packed {
    logic       found;
    logic [3:0] ebytes;
    logic [1:0] ekind;
  } nhd_type_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_EMIT,
    BK_FAIL
  } nhd_bk_state_t;

  function automatic nhd_type_t type_lookup(input logic [15:0] dtype);
    nhd_type_t t;
    t = '{found: 1'b1, ebytes: 4'd0, ekind: EK_UNSIGNED};
    case (dtype)
      16'd2:    begin t.ebytes = 4'd1; t.ekind = EK_UNSIGNED; end
      16'd4:    begin t.ebytes = 4'd2; t.ekind = EK_SIGNED;   end
      16'd8:    begin t.ebytes = 4'd4; t.ekind = EK_SIGNED;   end
      16'd16:   begin t.ebytes = 4'd4; t.ekind = EK_FLOAT;    end
      16'd64:   begin t.ebytes = 4'd8; t.ekind = EK_FLOAT;    end
      16'd256:  begin t.ebytes = 4'd1; t.ekind = EK_SIGNED;   end
      16'd512:  begin t.ebytes = 4'd2; t.ekind = EK_UNSIGNED; end
      16'd768:  begin t.ebytes = 4'd4; t.ekind = EK_UNSIGNED; end
      16'd1024: begin t.ebytes = 4'd8; t.ekind = EK_SIGNED;   end
      16'd1280: begin t.ebytes = 4'd8; t.ekind = EK_UNSIGNED; end
      default:  t.found = 1'b0;
    endcase
    return t;
  endfunction

  // raw is in file order (first byte in the top bits)
  function automatic logic [15:0] ord16(input logic [15:0] raw, input logic big);
    return big ? raw : {raw[7:0], raw[15:8]};
  endfunction

  function automatic logic [31:0] ord32(input logic [31:0] raw, input logic big);
    logic [31:0] r;
    for (int i = 0; i < 4; i++) r[8*i +: 8] = raw[8*(3-i) +: 8];
    return big ? raw : r;
  endfunction

  function automatic logic [63:0] ord64(input logic [63:0] raw, input logic big);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) r[8*i +: 8] = raw[8*(7-i) +: 8];
    return big ? raw : r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/nhd_jobq.sv @@
// ----------------------------------------------------------------------------
// nhd_jobq
// Two-entry queue of decoded headers between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module nhd_jobq
  import nhd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_en,
  input  wire nhd_job_t wr_job,
  output logic          q_full,
  input  wire logic     rd_en,
  output nhd_job_t      rd_job,
  output logic          q_empty
);

  nhd_job_t   slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign rd_job  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en && !q_full) slot_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en && !q_full) wp_r <= ~wp_r;
      if (rd_en && !q_empty) rp_r <= ~rp_r;
      case ({wr_en && !q_full, rd_en && !q_empty})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/nhd_front.sv @@
// ----------------------------------------------------------------------------
// nhd_front
// Byte intake: keeps the header bytes the checks need, then decodes them.
// ----------------------------------------------------------------------------
`default_nettype none

module nhd_front
  import nhd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  wire nhd_in_t  in_item,
  output logic          q_push,
  output nhd_job_t      q_job,
  input  wire logic     q_full
);

  // only the byte ranges that a check reads are kept
  logic [7:0] lo_r  [80];   // bytes 0..79
  logic [7:0] v1t_r [4];    // bytes 70..73
  logic [7:0] v1f_r [8];    // bytes 108..115
  logic [7:0] v2o_r [16];   // bytes 168..183
  logic [7:0] v1m_r [4];    // bytes 344..347

  logic [9:0] cnt_r;
  logic       eval_r;

  logic take;
  assign take   = push && !full;
  assign full   = eval_r;
  assign q_push = eval_r && !q_full;

  always_ff @(posedge clk) begin
    if (take && cnt_r < STORE_SIZE) begin
      if (cnt_r < 10'd80) lo_r[cnt_r[6:0]] <= in_item.header_byte;
      if (cnt_r inside {[10'd70:10'd73]}) v1t_r[2'(cnt_r - 10'd70)] <= in_item.header_byte;
      if (cnt_r inside {[10'd108:10'd115]}) v1f_r[3'(cnt_r - 10'd108)] <= in_item.header_byte;
      if (cnt_r inside {[10'd168:10'd183]}) v2o_r[4'(cnt_r - 10'd168)] <= in_item.header_byte;
      if (cnt_r inside {[10'd344:10'd347]}) v1m_r[2'(cnt_r - 10'd344)] <= in_item.header_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 10'd0;
      eval_r <= 1'b0;
    end else if (q_push) begin
      cnt_r  <= 10'd0;
      eval_r <= 1'b0;
    end else if (take) begin
      if (cnt_r < STORE_SIZE) cnt_r <= cnt_r + 10'd1;
      eval_r <= in_item.final_byte;
    end
  end

  // decode
  logic [31:0]      raw_size, word_le, hsize;
  logic             big, two, single, paired, ext_bad, fw_ok, off_neg;
  logic [63:0]      dims [8];
  logic [15:0]      dtype, bitpix;
  nhd_type_t        tinfo;
  logic [63:0]      off64, slope64;
  logic [31:0]      fbits, slope32;
  logic [7:0]       fex;
  logic [23:0]      fman, fmask;
  logic [4:0]       sh_dn;
  logic [62:0]      fval, offset;
  logic [2:0]       rank;
  logic             rank_ok;

  always_comb begin
    raw_size = {lo_r[0], lo_r[1], lo_r[2], lo_r[3]};
    word_le  = ord32(raw_size, 1'b0);
    big      = !(word_le == HDR_ONE || word_le == HDR_TWO);
    hsize    = ord32(raw_size, big);
    two      = (hsize == HDR_TWO);

    if (two) begin
      single = lo_r[4] == CH_N && lo_r[5] == CH_PLUS && lo_r[6] == CH_TWO;
      paired = lo_r[4] == CH_N && lo_r[5] == CH_I && lo_r[6] == CH_TWO;
      if (!(lo_r[7] == 8'h00 && lo_r[8] == 8'h0D && lo_r[9] == 8'h0A &&
            lo_r[10] == 8'h1A && lo_r[11] == 8'h0A)) begin
        single = 1'b0;
        paired = 1'b0;
      end
    end else begin
      single = v1m_r[0] == CH_N && v1m_r[1] == CH_PLUS && v1m_r[2] == CH_ONE &&
               v1m_r[3] == 8'h00;
      paired = v1m_r[0] == CH_N && v1m_r[1] == CH_I && v1m_r[2] == CH_ONE &&
               v1m_r[3] == 8'h00;
    end

    for (int j = 0; j < 8; j++) begin
      if (two)
        dims[j] = ord64({lo_r[16+8*j], lo_r[17+8*j], lo_r[18+8*j], lo_r[19+8*j],
                         lo_r[20+8*j], lo_r[21+8*j], lo_r[22+8*j], lo_r[23+8*j]}, big);
      else
        dims[j] = {48'd0, ord16({lo_r[40+2*j], lo_r[41+2*j]}, big)};
    end
    rank_ok = (dims[0] >= 64'd1) && (dims[0] <= 64'(MAX_RANK));
    rank    = dims[0][2:0];

    dtype  = two ? ord16({lo_r[12], lo_r[13]}, big) : ord16({v1t_r[0], v1t_r[1]}, big);
    bitpix = two ? ord16({lo_r[14], lo_r[15]}, big) : ord16({v1t_r[2], v1t_r[3]}, big);
    tinfo  = type_lookup(dtype);

    ext_bad = 1'b0;
    for (int j = 0; j < MAX_RANK; j++) begin
      if (3'(j) < rank) begin
        if (dims[j+1] == 64'd0 || (two ? dims[j+1][63] : dims[j+1][15])) ext_bad = 1'b1;
      end
    end

    off64   = ord64({v2o_r[0], v2o_r[1], v2o_r[2], v2o_r[3],
                     v2o_r[4], v2o_r[5], v2o_r[6], v2o_r[7]}, big);
    slope64 = ord64({v2o_r[8], v2o_r[9], v2o_r[10], v2o_r[11],
                     v2o_r[12], v2o_r[13], v2o_r[14], v2o_r[15]}, big);
    fbits   = ord32({v1f_r[0], v1f_r[1], v1f_r[2], v1f_r[3]}, big);
    slope32 = ord32({v1f_r[4], v1f_r[5], v1f_r[6], v1f_r[7]}, big);

    // float32 offset to a whole number
    fex   = fbits[30:23];
    fman  = {1'b1, fbits[22:0]};
    sh_dn = 5'(8'd150 - fex);
    fmask = (24'd1 << sh_dn) - 24'd1;
    fval  = 63'd0;
    fw_ok = 1'b1;
    if (fbits[30:0] == 31'd0) begin
      fval = 63'd0;
    end else if (fbits[31] || fex < 8'd127 || fex > 8'd189) begin
      fw_ok = 1'b0;
    end else if (fex >= 8'd150) begin
      fval = 63'(fman) << 6'(fex - 8'd150);
    end else begin
      fw_ok = ((fman & fmask) == 24'd0);
      fval  = 63'(fman >> sh_dn);
    end

    offset  = two ? off64[62:0] : fval;
    off_neg = two ? off64[63] : !fw_ok;

    q_job.off_bad = off_neg || (single && {1'b0, offset} < {32'd0, hsize});
    q_job.offset  = offset;
    q_job.rank    = rank;
    q_job.ebytes  = tinfo.ebytes;
    q_job.ekind   = tinfo.ekind;
    q_job.swap    = big && (tinfo.ebytes > 4'd1);
    q_job.paired  = paired;
    q_job.scaled  = two ? (slope64[62:0] != 63'd0 && slope64 != ONE_F64)
                        : (slope32[30:0] != 31'd0 && slope32 != ONE_F32);
    for (int j = 0; j < MAX_RANK; j++) q_job.ext[j] = dims[j+1][62:0];

    if (cnt_r < HDR_ONE[9:0])                          q_job.code = ST_SHORT;
    else if (hsize != HDR_ONE && hsize != HDR_TWO)     q_job.code = ST_SIZE;
    else if ({22'd0, cnt_r} < hsize)                   q_job.code = ST_SHORT;
    else if (!single && !paired)                       q_job.code = ST_MAGIC;
    else if (!rank_ok)                                 q_job.code = ST_RANK;
    else if (!tinfo.found || bitpix != {9'd0, tinfo.ebytes, 3'd0})
                                                       q_job.code = ST_TYPE;
    else if (ext_bad)                                  q_job.code = ST_EXTENT;
    else                                               q_job.code = ST_OK;
  end

endmodule

`default_nettype wire

@@ rtl/core/nhd_back.sv @@
// ----------------------------------------------------------------------------
// nhd_back
// Extent product with overflow check (bit-serial) and result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module nhd_back
  import nhd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire nhd_job_t q_job,
  input  wire logic     q_empty,
  output logic          q_pop,
  output logic          empty,
  input  wire logic     pop,
  output nhd_out_t      out_item
);

  nhd_bk_state_t st_r, st_nxt;
  nhd_job_t      job_r, job_nxt;
  logic [2:0]    code_r, code_nxt;
  logic [2:0]    ax_r, ax_nxt;
  logic [5:0]    bit_r, bit_nxt;
  logic [62:0]   acc_r, acc_nxt;
  logic [62:0]   total_r, total_nxt;
  logic [3:0]    k_r, k_nxt;
  logic          ovalid_r, ovalid_nxt;
  nhd_out_t      out_r, out_nxt;

  logic          ld_ok;
  logic [64:0]   sum;
  logic [62:0]   ext_cur;
  logic [2:0]    slot;

  assign empty    = !ovalid_r;
  assign out_item = out_r;
  assign ld_ok    = !ovalid_r || pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= BK_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    code_r  <= code_nxt;
    ax_r    <= ax_nxt;
    bit_r   <= bit_nxt;
    acc_r   <= acc_nxt;
    total_r <= total_nxt;
    k_r     <= k_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    st_nxt     = st_r;
    job_nxt    = job_r;
    code_nxt   = code_r;
    ax_nxt     = ax_r;
    bit_nxt    = bit_r;
    acc_nxt    = acc_r;
    total_nxt  = total_r;
    k_nxt      = k_r;
    out_nxt    = out_r;
    ovalid_nxt = ovalid_r && !pop;
    q_pop      = 1'b0;

    // MSB-first shift-add; acc never exceeds the byte limit while running
    ext_cur = job_r.ext[ax_r];
    sum     = {1'b0, acc_r, 1'b0} + (ext_cur[bit_r] ? {2'b0, total_r} : 65'd0);
    slot    = job_r.rank - k_r[2:0];

    case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_job;
          code_nxt  = q_job.code;
          ax_nxt    = 3'd0;
          bit_nxt   = 6'd62;
          acc_nxt   = 63'd0;
          total_nxt = 63'(q_job.ebytes);
          k_nxt     = 4'd0;
          st_nxt    = (q_job.code != ST_OK) ? BK_FAIL : BK_MUL;
        end
      end
      BK_MUL: begin
        if (sum[64:63] != 2'b00) begin
          code_nxt = ST_EXTENT;
          st_nxt   = BK_FAIL;
        end else if (bit_r == 6'd0) begin
          total_nxt = sum[62:0];
          acc_nxt   = 63'd0;
          bit_nxt   = 6'd62;
          ax_nxt    = ax_r + 3'd1;
          if (ax_r == job_r.rank - 3'd1) begin
            code_nxt = ST_OFFSET;
            st_nxt   = job_r.off_bad ? BK_FAIL : BK_EMIT;
          end
        end else begin
          acc_nxt = sum[62:0];
          bit_nxt = bit_r - 6'd1;
        end
      end
      BK_FAIL: begin
        if (ld_ok) begin
          out_nxt        = '0;
          out_nxt.status = code_r;
          out_nxt.last   = 1'b1;
          ovalid_nxt     = 1'b1;
          st_nxt         = BK_IDLE;
        end
      end
      BK_EMIT: begin
        if (ld_ok) begin
          out_nxt               = '0;
          out_nxt.status        = ST_OK;
          out_nxt.elem_size     = job_r.ebytes;
          out_nxt.elem_class    = job_r.ekind;
          out_nxt.rank          = job_r.rank;
          out_nxt.swap_bytes    = job_r.swap;
          out_nxt.paired_files  = job_r.paired;
          out_nxt.scaled        = job_r.scaled;
          if (k_r < {1'b0, job_r.rank}) begin
            out_nxt.record_kind = RK_AXIS;
            out_nxt.axis_index  = k_r[2:0];
            out_nxt.axis_label  = (slot <= 3'd4) ? slot : 3'd0;
            out_nxt.value       = job_r.ext[3'(slot - 3'd1)];
          end else if (k_r == {1'b0, job_r.rank}) begin
            out_nxt.record_kind = RK_OFFSET;
            out_nxt.value       = job_r.offset;
          end else begin
            out_nxt.record_kind = RK_TOTAL;
            out_nxt.value       = total_r;
            out_nxt.last        = 1'b1;
            st_nxt              = BK_IDLE;
          end
          ovalid_nxt = 1'b1;
          k_nxt      = k_r + 4'd1;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/nifti_header_decoder.sv @@
// ----------------------------------------------------------------------------
// nifti_header_decoder
// Volume header checker: byte intake, decode queue, extent product, results.
// ----------------------------------------------------------------------------
// Header bytes are taken one per cycle. The item with final_byte set closes a
// header; intake then pauses while the kept bytes are decoded into a two-deep
// header queue (intake also pauses while that queue is full). The back end
// works one queued header at a time: the extent product runs bit-serially,
// axis by axis, before a good header's rank+2 results (axes slowest first,
// data offset, total bytes) leave at one per cycle while the output is popped.
// A header that fails before the product gives one status result right away;
// an extent overflow is found while the product runs and a bad data offset
// once it has run, and either then gives its one status result.
// ----------------------------------------------------------------------------
`default_nettype none

module nifti_header_decoder
  import nhd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  output logic         full,
  input  wire nhd_in_t in_item,
  output logic         empty,
  input  wire logic    pop,
  output nhd_out_t     out_item
);

  nhd_job_t wr_job, rd_job;
  logic     q_push, q_full, q_pop, q_empty;

  nhd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_push  (q_push),
    .q_job   (wr_job),
    .q_full  (q_full)
  );

  nhd_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_job  (wr_job),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_job  (rd_job),
    .q_empty (q_empty)
  );

  nhd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_job    (rd_job),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
